### sv/plist_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared word types, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FPOS_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } plist_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [FPOS_W-1:0]       found_position;
    logic [COUNT_W-1:0]      count;
  } plist_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_SCAN,
    S_WAIT_RD,
    S_RESULT
  } plist_state_t;

endpackage

`default_nettype wire

### sv/plist_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/plist_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list sequencer
// Decodes one operation, then walks the entry RAM to shift, scan or read it.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ctrl
  import plist_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(CAPACITY)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire plist_in_t              in_word,
  output logic                        in_stall,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output plist_out_t                  res_word,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [VALUE_WIDTH-1:0]      ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  wire logic [VALUE_WIDTH-1:0] ram_rdata
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  plist_state_t           state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [POS_W-1:0]       pos_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  plist_out_t             res_r, res_nxt;

  logic            take_in;
  logic [CMP_W-1:0] pos_e, cnt_e;
  logic [AW-1:0]   pos_a, last_a;
  logic            ins_bad, acc_bad, full, pos_at_end, pos_at_last, cnt_zero;
  logic            at_pos, at_last, match;

  assign take_in     = in_valid && (state_r == S_IDLE);
  assign in_stall    = (state_r != S_IDLE);
  assign res_valid   = (state_r == S_RESULT);

  assign pos_e       = CMP_W'(pos_r);
  assign cnt_e       = CMP_W'(cnt_r);
  assign pos_a       = AW'(pos_r);
  assign last_a      = AW'(cnt_r - CW'(1));
  assign ins_bad     = pos_e > cnt_e;
  assign acc_bad     = pos_e >= cnt_e;
  assign full        = (cnt_r == CW'(CAPACITY));
  assign pos_at_end  = (pos_e == cnt_e);
  assign pos_at_last = (pos_a == last_a);
  assign cnt_zero    = (cnt_r == '0);
  assign at_pos      = (idx_r == pos_a);
  assign at_last     = (idx_r == last_a);
  assign match       = (ram_rdata == val_r);

  always_comb begin
    res_word       = res_r;
    res_word.count = COUNT_W'(cnt_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op_r)
          OP_INSERT: begin
            if (ins_bad || full || pos_at_end) begin
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_SHIFT_UP;
            end
          end
          OP_REMOVE: begin
            if (acc_bad || pos_at_last) begin
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_SHIFT_DN;
            end
          end
          OP_READ: state_nxt = acc_bad ? S_RESULT : S_WAIT_RD;
          OP_FIND: state_nxt = cnt_zero ? S_RESULT : S_SCAN;
          default: state_nxt = S_RESULT;
        endcase
      end
      S_SHIFT_UP: begin
        if (at_pos) begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR:   state_nxt = S_RESULT;
      S_SHIFT_DN: begin
        if (at_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_SCAN: begin
        if (match || at_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_WAIT_RD:  state_nxt = S_RESULT;
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_DISPATCH: begin
        res_nxt = '0;
        unique case (op_r)
          OP_INSERT: begin
            if (ins_bad) begin
              res_nxt.status = ST_RANGE;
            end else if (full) begin
              res_nxt.status = ST_FULL;
            end else if (pos_at_end) begin
              ram_we    = 1'b1;
              ram_waddr = pos_a;
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + CW'(1);
            end else begin
              idx_nxt   = last_a;
              ram_raddr = last_a;
            end
          end
          OP_REMOVE: begin
            if (acc_bad) begin
              res_nxt.status = ST_RANGE;
            end else if (pos_at_last) begin
              cnt_nxt = cnt_r - CW'(1);
            end else begin
              idx_nxt   = pos_a + AW'(1);
              ram_raddr = pos_a + AW'(1);
            end
          end
          OP_READ: begin
            if (acc_bad) begin
              res_nxt.status = ST_RANGE;
            end else begin
              ram_raddr = pos_a;
            end
          end
          OP_UPDATE: begin
            if (acc_bad) begin
              res_nxt.status = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_a;
              ram_wdata = val_r;
            end
          end
          OP_FIND: begin
            idx_nxt   = '0;
            ram_raddr = '0;
          end
          default: ;
        endcase
      end
      S_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        ram_wdata = ram_rdata;
        if (!at_pos) begin
          idx_nxt   = idx_r - AW'(1);
          ram_raddr = idx_r - AW'(1);
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
      end
      S_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (at_last) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end
      S_SCAN: begin
        if (match) begin
          res_nxt.found          = 1'b1;
          res_nxt.found_position = FPOS_W'(idx_r);
        end else if (!at_last) begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end
      S_WAIT_RD: begin
        res_nxt.read_value = VAL_W'(ram_rdata);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      op_r  <= in_word.operation;
      pos_r <= in_word.position;
      val_r <= VALUE_WIDTH'(in_word.value);
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

### sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed values with insert, remove, read, update and find.
// ----------------------------------------------------------------------------
// Input words carry operation, position and value; each gives exactly one
// output word with status, read value, find result and the entry count.
// One word is worked on at a time: in_stall is high from the cycle after
// acceptance until its result has moved into the output register.
// Entries live in one RAM with one write and one registered read port, and
// every moved or scanned entry passes through that port pair. An insert
// shifts the entries from the last down to the position up, then writes
// the new value; a remove shifts the entries after the position down; a
// find scans from entry 0 to a match or the last entry; a read waits on the
// read port; insert at the end, update and rejected words go to the result.
// The output register holds a finished word under out_stall while the next
// input word is already taken. Reset empties the list at once; entries are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine
  import plist_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire plist_in_t  in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output plist_out_t      out_word
);

  localparam int AW = $clog2(CAPACITY);

  logic                   res_valid, res_take;
  plist_out_t             res_word;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                   out_valid_r, out_valid_nxt;
  plist_out_t             out_word_r;

  plist_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_ready (res_take),
    .res_word  (res_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  plist_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### sv/plist_chk.sv
// ----------------------------------------------------------------------------
// Positional list engine port checker
// Watches the input and result channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_chk
  import plist_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire plist_in_t  in_word,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire plist_out_t out_word
);

  logic in_take;

  assign in_take = in_valid && !in_stall && (in_word.operation != OP_FIND);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.count <= COUNT_W'(CAPACITY_DEF))
    else $error("count above capacity");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |->
      !out_word.found && (out_word.read_value == '0))
    else $error("rejected operation returned data");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.found |-> out_word.found_position == '0)
    else $error("position reported without a match");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("second word taken while busy");

endmodule

bind positional_list_engine plist_chk u_plist_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

### dv/tb_positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, remove, read, update, find and unused-code words through the valid/stall
// input channel, keeps a shadow copy of the list to predict every output
// word, and compares each output word field by field in arrival order.
// Both channels idle at random, with one stretch that runs back to back.
// ----------------------------------------------------------------------------

module tb_positional_list_engine;
  import plist_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [POS_W-1:0] POS_TOP = 7'd127;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  plist_in_t  in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  plist_out_t out_word;

  logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
  int         shadow_count = 0;
  plist_out_t pending_results [$];
  plist_out_t want;
  int         errors = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("[positional_list_engine] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic plist_in_t make_word(input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic signed [VAL_W-1:0] val);
    plist_in_t w;
    w.operation = op;
    w.position  = pos;
    w.value     = val;
    return w;
  endfunction

  function automatic plist_out_t predict_list_op(input plist_in_t w);
    plist_out_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_INSERT: begin
        if (w.position > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > w.position; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[w.position] = w.value;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (w.position >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = w.position; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (w.position >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_entries[w.position];
      end
      OP_UPDATE: begin
        if (w.position >= shadow_count) r.status = ST_RANGE;
        else shadow_entries[w.position] = w.value;
      end
      OP_FIND: begin
        for (i = 0; i < shadow_count; i++) begin
          if (!r.found && shadow_entries[i] == w.value) begin
            r.found = 1'b1;
            r.found_position = i[FPOS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
    int top;
    int r;
    top = for_insert ? shadow_count : shadow_count - 1;
    r = $urandom_range(0, 99);
    if (r < 85 && top >= 0) return POS_W'($urandom_range(0, top));
    if (r < 95) return POS_W'(top + 1);
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && shadow_count > 0) return shadow_entries[$urandom_range(0, shadow_count - 1)];
    if (r < 50) return $signed($urandom_range(0, 4)) - 2;
    if (r < 58) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic plist_in_t random_word(input int w_ins, input int w_rem);
    logic [OP_W-1:0] op;
    int r;
    int s;
    r = $urandom_range(0, w_ins + w_rem + 99);
    s = $urandom_range(0, 99);
    if (r < w_ins) op = OP_INSERT;
    else if (r < w_ins + w_rem) op = OP_REMOVE;
    else if (s < 30) op = OP_READ;
    else if (s < 55) op = OP_UPDATE;
    else if (s < 97) op = OP_FIND;
    else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    return make_word(op, pick_position(op == OP_INSERT), pick_value());
  endfunction

  task automatic send_word(input plist_in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        in_word <= {OP_W'($urandom), POS_W'($urandom), VAL_W'($urandom)};
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_list_op(w));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic run_random_ops(input int n_items, input int w_ins, input int w_rem);
    repeat (n_items) send_word(random_word(w_ins, w_rem));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output word %p", out_word);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          errors++;
        end
        if (out_word.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_word.read_value);
          errors++;
        end
        if (out_word.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_word.found);
          errors++;
        end
        if (out_word.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, out_word.found_position);
          errors++;
        end
        if (out_word.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_word.count);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_and_edges();
    send_word(make_word(OP_FIND, 7'd0, 32'sd0));
    send_word(make_word(OP_READ, 7'd0, 32'sd0));
    send_word(make_word(OP_REMOVE, 7'd0, 32'sd0));
    send_word(make_word(OP_UPDATE, 7'd0, 32'sd9));
    send_word(make_word(OP_INSERT, 7'd1, 32'sd9));
    send_word(make_word(OP_SPARE_LAST, POS_TOP, VAL_MIN));
    send_word(make_word(OP_INSERT, 7'd0, VAL_MAX));
    send_word(make_word(OP_INSERT, 7'd1, VAL_MIN));
    send_word(make_word(OP_INSERT, 7'd1, -32'sd1));
    send_word(make_word(OP_INSERT, 7'd0, 32'sd0));
    send_word(make_word(OP_READ, 7'd3, 32'sd0));
    send_word(make_word(OP_READ, 7'd4, 32'sd0));
    send_word(make_word(OP_READ, POS_TOP, -32'sd1));
    send_word(make_word(OP_UPDATE, 7'd2, VAL_MAX));
    send_word(make_word(OP_FIND, POS_TOP, VAL_MAX));
    send_word(make_word(OP_FIND, 7'd0, 32'sd12345));
    send_word(make_word(OP_UPDATE, 7'd0, VAL_MIN));
    send_word(make_word(OP_FIND, 7'd0, VAL_MIN));
    send_word(make_word(OP_REMOVE, 7'd3, 32'sd0));
    send_word(make_word(OP_REMOVE, 7'd0, 32'sd0));
    send_word(make_word(OP_INSERT, 7'd2, 32'sd5));
    send_word(make_word(OP_SPARE_FIRST, 7'd0, 32'sd5));
    send_word(make_word(OP_REMOVE, 7'd64, 32'sd0));
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    run_random_ops(600, 45, 30);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [VAL_W-1:0] fresh;
    bit clash;
    int i;
    while (shadow_count < LIST_DEPTH) send_word(random_word(400, 20));
    send_word(make_word(OP_INSERT, 7'd0, 32'sd1));
    send_word(make_word(OP_INSERT, 7'd64, 32'sd1));
    send_word(make_word(OP_INSERT, 7'd65, 32'sd1));
    send_word(make_word(OP_INSERT, POS_TOP, 32'sd1));
    send_word(make_word(OP_READ, 7'd63, 32'sd0));
    do begin
      fresh = $urandom;
      clash = 1'b0;
      for (i = 0; i < shadow_count; i++)
        if (shadow_entries[i] == fresh) clash = 1'b1;
    end while (clash);
    send_word(make_word(OP_UPDATE, 7'd63, fresh));
    send_word(make_word(OP_FIND, 7'd0, fresh));
    send_word(make_word(OP_REMOVE, 7'd63, 32'sd0));
    send_word(make_word(OP_INSERT, 7'd63, fresh));
    run_random_ops(150, 60, 60);
    while (shadow_count > 0) send_word(random_word(20, 400));
    send_word(make_word(OP_FIND, 7'd0, fresh));
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_random_ops(300, 50, 30);
    no_idle = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_paused_phases();
    repeat (4) begin
      run_random_ops(100, 40, 40);
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_edges();
    test_random_mix();
    test_fill_to_capacity();
    test_back_to_back();
    test_paused_phases();
    wait_results_drained();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("[positional_list_engine] OK");
    end else begin
      $display("[positional_list_engine] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/plist_pkg.sv
sv/plist_ram.sv
sv/plist_ctrl.sv
sv/positional_list_engine.sv
sv/plist_chk.sv
dv/tb_positional_list_engine.sv
